FILE: sv/sme_pkg.sv
// Shared types and constants for the stack machine execute unit.
package sme_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_REG_COUNT   = 8;
    localparam int DEF_RAM_DEPTH   = 128;
    localparam int DEF_CODE_DEPTH  = 4096;

    localparam int LETTER_BASE = 65;  // 'A' selects register 0
    localparam int NPC_W       = 34;  // signed working width for PC arithmetic
    localparam int CSZ_W       = 13;
    localparam logic [12:0] CODE_SIZE_RST = 13'd4096;

    typedef enum logic [4:0] {
        OP_PUSH    = 5'd0,
        OP_IN      = 5'd1,
        OP_ADD     = 5'd2,
        OP_SUB     = 5'd3,
        OP_MUL     = 5'd4,
        OP_DIV     = 5'd5,
        OP_REM     = 5'd6,
        OP_SQRT    = 5'd7,
        OP_POW     = 5'd8,
        OP_OUT     = 5'd9,
        OP_HLT     = 5'd10,
        OP_PUSHREG = 5'd11,
        OP_POPREG  = 5'd12,
        OP_JB      = 5'd13,
        OP_JBE     = 5'd14,
        OP_JA      = 5'd15,
        OP_JAE     = 5'd16,
        OP_JE      = 5'd17,
        OP_JNE     = 5'd18,
        OP_JMP     = 5'd19,
        OP_CALL    = 5'd20,
        OP_RET     = 5'd21,
        OP_PUSHM   = 5'd22,
        OP_POPM    = 5'd23,
        OP_DRAW    = 5'd24
    } t_op;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_UNDERFLOW = 4'd1;
    localparam logic [3:0] ERR_OVERFLOW  = 4'd2;
    localparam logic [3:0] ERR_ZERO_DIV  = 4'd3;
    localparam logic [3:0] ERR_NEG_SQRT  = 4'd4;
    localparam logic [3:0] ERR_BAD_INDEX = 4'd5;
    localparam logic [3:0] ERR_BAD_OP    = 4'd6;
    localparam logic [3:0] ERR_PC_RANGE  = 4'd7;
    localparam logic [3:0] ERR_RET_STACK = 4'd8;

    localparam logic [0:0] REG_CODE_SIZE = 1'b0;

    typedef enum logic [2:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_REM,
        ALU_SQRT,
        ALU_POW
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

FILE: sv/sme_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module sme_ram
    import sme_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/sme_dram.sv
// Data RAM with per-entry valid bits so that unwritten words read as zero.
module sme_dram
    import sme_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0]    mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [31:0]    r_rdata;
    logic           r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 32'd0;

endmodule

FILE: sv/sme_alu.sv
// Arithmetic unit: multiply in one step; multicycle divide/remainder, square root, power.
module sme_alu
    import sme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_alu_req    i_req,
    input  logic [31:0] i_a,    // y, second from top
    input  logic [31:0] i_b,    // x, top of stack
    input  logic [31:0] i_exp,
    output logic        o_done,
    output logic [31:0] o_result
);

    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;
    logic [31:0] r_res;
    logic [31:0] r_q;      // quotient / sqrt value / pow accumulator
    logic [31:0] r_rem;    // remainder / sqrt root / pow base
    logic [31:0] r_div;    // divisor / sqrt bit / exponent
    logic [5:0]  r_cnt;
    logic        r_neg_q;
    logic        r_neg_r;

    logic [32:0] div_sh;
    logic [32:0] div_sub;
    logic [31:0] sq_trial;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    assign mag_a    = i_a[31] ? (32'd0 - i_a) : i_a;
    assign mag_b    = i_b[31] ? (32'd0 - i_b) : i_b;
    assign div_sh   = {r_rem, r_q[31]};
    assign div_sub  = div_sh - {1'b0, r_div};
    assign sq_trial = r_rem + r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op <= i_req.op;
                case (i_req.op)
                    ALU_MUL: begin
                        r_res  <= i_a * i_b;
                        r_done <= 1'b1;
                    end
                    ALU_DIV, ALU_REM: begin
                        r_busy  <= 1'b1;
                        r_q     <= mag_a;
                        r_rem   <= 32'd0;
                        r_div   <= mag_b;
                        r_cnt   <= 6'd32;
                        r_neg_q <= i_a[31] ^ i_b[31];
                        r_neg_r <= i_a[31];
                    end
                    ALU_SQRT: begin
                        r_busy <= 1'b1;
                        r_q    <= i_b;
                        r_rem  <= 32'd0;
                        r_div  <= 32'h4000_0000;
                    end
                    ALU_POW: begin
                        r_busy <= 1'b1;
                        r_q    <= 32'd1;
                        r_rem  <= i_b;
                        r_div  <= i_exp;
                    end
                    default: begin
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    ALU_DIV, ALU_REM: begin
                        if (r_cnt == 6'd0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            if (r_op == ALU_DIV) begin
                                r_res <= r_neg_q ? (32'd0 - r_q) : r_q;
                            end else begin
                                r_res <= r_neg_r ? (32'd0 - r_rem) : r_rem;
                            end
                        end else begin
                            r_cnt <= r_cnt - 6'd1;
                            if (!div_sub[32]) begin
                                r_rem <= div_sub[31:0];
                                r_q   <= {r_q[30:0], 1'b1};
                            end else begin
                                r_rem <= div_sh[31:0];
                                r_q   <= {r_q[30:0], 1'b0};
                            end
                        end
                    end
                    ALU_SQRT: begin
                        if (r_div == 32'd0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= r_rem;
                        end else begin
                            r_div <= r_div >> 2;
                            if (r_q >= sq_trial) begin
                                r_q   <= r_q - sq_trial;
                                r_rem <= (r_rem >> 1) + r_div;
                            end else begin
                                r_rem <= r_rem >> 1;
                            end
                        end
                    end
                    ALU_POW: begin
                        if (r_div == 32'd0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_res  <= r_q;
                        end else begin
                            if (r_div[0]) begin
                                r_q <= r_q * r_rem;
                            end
                            r_rem <= r_rem * r_rem;
                            r_div <= r_div >> 1;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

FILE: sv/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit.
//
// Executes one fetched instruction per input transaction and returns exactly
// one result transaction (next PC, OUT value, halt flag, error code). The data
// stack and the return stack live in synchronous RAMs with a registered read
// port; the data RAM is a third RAM with per-word valid bits so that it
// reads as zero after reset without a clearing pass. The register file is a
// small flop array. An instruction is decoded, its stack operands are read one
// per cycle, it executes, and all writes are committed in a single cycle, so
// no two instructions ever touch the same entry at once. DIV and REM use a
// 32-step restoring divider, SQRT takes 16 digit steps, and POW uses
// square-and-multiply, one exponent bit per cycle; DIV and REM are the slowest
// operations. The next instruction can be accepted in the cycle after the
// previous result is loaded into the output register. Errors and HLT are
// sticky: later transactions are answered with the held PC and latched error
// code. The code size register sits at byte address 0 of the APB port.
module stack_machine_execute_unit
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int REG_COUNT   = DEF_REG_COUNT,
    parameter int RAM_DEPTH   = DEF_RAM_DEPTH,
    parameter int CODE_DEPTH  = DEF_CODE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // instruction channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [4:0]         i_action,
    input  logic signed [31:0] i_argument,
    input  logic signed [31:0] i_in_value,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [11:0]        o_next_pc,
    output logic signed [31:0] o_out_value,
    output logic               o_out_valid,
    output logic               o_halted,
    output logic [3:0]         o_error_code,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SI_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int PC_W = $clog2(CODE_DEPTH);
    localparam int RA_W = $clog2(RAM_DEPTH);
    localparam int RI_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int RS_W = PC_W + 1;   // return address can equal CODE_DEPTH

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_X,
        S_Y,
        S_EXEC,
        S_ALU,
        S_RD,      // waits on data RAM or return stack read
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state exec_state;   // where S_EXEC goes next
    logic [3:0] dec_err;  // fault found at decode

    // configuration
    logic [CSZ_W-1:0] r_code_size;
    logic             cfg_wr;

    // architectural state
    logic [PC_W-1:0]  r_pc;
    logic [SP_W-1:0]  r_dsp;
    logic [SP_W-1:0]  r_rsp;
    logic             r_stopped;
    logic [3:0]       r_err;
    logic [31:0]      r_regs [REG_COUNT];

    // instruction being worked on
    logic [4:0]              r_op;
    logic [31:0]             r_arg;
    logic [31:0]             r_inv;
    logic [31:0]             r_x;
    logic [31:0]             r_y;
    logic [31:0]             r_pv;
    logic signed [NPC_W-1:0] r_npc;
    logic [1:0]              r_pops;
    logic [3:0]              r_err_pend;
    logic                    r_held;   // block was already stopped at accept
    logic                    r_push;
    logic                    r_halt;
    logic                    r_outok;
    logic                    r_wreg;
    logic                    r_wmem;
    logic                    r_rpush;
    logic                    r_rpop;
    logic [RI_W-1:0]         r_ridx;
    logic [RA_W-1:0]         r_maddr;

    // output register
    logic              r_o_valid;
    logic [11:0]       r_o_pc;
    logic [31:0]       r_o_val;
    logic              r_o_ovld;
    logic              r_o_halt;
    logic [3:0]        r_o_err;

    // decode helpers
    logic signed [NPC_W-1:0] pc_ext;
    logic signed [NPC_W-1:0] sarg_ext;
    logic signed [NPC_W-1:0] lim_ext;
    logic signed [NPC_W-1:0] ri_ext;
    logic                    ri_ok;
    logic [RI_W-1:0]         ri_idx;
    logic [31:0]             reg_val;
    logic                    maddr_ok;
    logic [1:0]              dec_pops;
    logic                    take;
    logic                    out_free;

    // memory and unit controls
    logic            ds_we, ds_re;
    logic [SI_W-1:0] ds_waddr, ds_raddr;
    logic [31:0]     ds_rdata;
    logic            rs_we, rs_re;
    logic [SI_W-1:0] rs_waddr, rs_raddr;
    logic [RS_W-1:0] rs_wdata, rs_rdata;
    logic            dm_we, dm_re;
    logic [31:0]     dm_rdata;
    t_alu_req        alu_req;
    logic            alu_done;
    logic [31:0]     alu_res;

    // commit helpers
    logic [SP_W-1:0] dsp_after;
    logic [3:0]      fin_err;
    logic            commit_ok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CODE_SIZE);
    assign prdata = (paddr[2] == REG_CODE_SIZE) ? {{(32 - CSZ_W){1'b0}}, r_code_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_size <= CODE_SIZE_RST;
        end else if (cfg_wr) begin
            r_code_size <= pwdata[CSZ_W-1:0];
        end
    end

    assign take     = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    assign pc_ext   = $signed({{(NPC_W - PC_W){1'b0}}, r_pc});
    assign sarg_ext = $signed({{(NPC_W - 32){r_arg[31]}}, r_arg});
    assign lim_ext  = (r_code_size < CODE_DEPTH)
                    ? $signed({{(NPC_W - CSZ_W){1'b0}}, r_code_size})
                    : NPC_W'(CODE_DEPTH);
    assign ri_ext   = sarg_ext - NPC_W'(LETTER_BASE);
    assign ri_ok    = (ri_ext >= 0) && (ri_ext < NPC_W'(REG_COUNT));
    assign ri_idx   = ri_ext[RI_W-1:0];
    assign reg_val  = r_regs[ri_idx];
    assign maddr_ok = (reg_val < RAM_DEPTH);

    // operand count by opcode
    always_comb begin
        case (r_op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM,
            OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: dec_pops = 2'd2;
            OP_SQRT, OP_POW, OP_OUT, OP_POPREG, OP_POPM:  dec_pops = 2'd1;
            default:                                      dec_pops = 2'd0;
        endcase
    end

    // decode checks in priority order: PC range, opcode, underflow
    always_comb begin
        dec_err = ERR_NONE;
        if (r_stopped) begin
            dec_err = ERR_NONE;
        end else if (pc_ext >= lim_ext) begin
            dec_err = ERR_PC_RANGE;
        end else if (r_op > OP_DRAW) begin
            dec_err = ERR_BAD_OP;
        end else if (r_dsp < SP_W'(dec_pops)) begin
            dec_err = ERR_UNDERFLOW;
        end
    end

    // multicycle units and reads that follow S_EXEC
    always_comb begin
        exec_state = S_COMMIT;
        case (r_op)
            OP_MUL:         exec_state = S_ALU;
            OP_DIV, OP_REM: if (r_x != 32'd0) exec_state = S_ALU;
            OP_SQRT:        if (!r_x[31]) exec_state = S_ALU;
            OP_POW:         if ($signed(r_arg) > 1) exec_state = S_ALU;
            OP_PUSHM:       if (ri_ok && maddr_ok) exec_state = S_RD;
            OP_RET:         if (r_rsp != '0) exec_state = S_RD;
            default: ;
        endcase
    end

    // commit checks: overflow on push, then the new PC range
    assign dsp_after = r_dsp - SP_W'(r_pops);
    always_comb begin
        fin_err = r_err_pend;
        if (fin_err == ERR_NONE && r_push && dsp_after == SP_W'(STACK_DEPTH)) begin
            fin_err = ERR_OVERFLOW;
        end
        if (fin_err == ERR_NONE && !r_halt && (r_npc < 0 || r_npc >= lim_ext)) begin
            fin_err = ERR_PC_RANGE;
        end
    end
    assign commit_ok = (r_state == S_COMMIT) && out_free && !r_held;

    // memory controls
    always_comb begin
        ds_re    = 1'b0;
        ds_raddr = SI_W'(r_dsp - SP_W'(1));
        rs_re    = 1'b0;
        rs_raddr = SI_W'(r_rsp - SP_W'(1));
        dm_re    = 1'b0;
        alu_req  = '{start: 1'b0, op: ALU_MUL};
        case (r_state)
            S_DEC: begin
                ds_re = !r_stopped && (dec_pops != 2'd0);
            end
            S_X: begin
                ds_re    = (r_pops == 2'd2);
                ds_raddr = SI_W'(r_dsp - SP_W'(2));
            end
            S_EXEC: begin
                if (r_err_pend == ERR_NONE) begin
                    case (r_op)
                        OP_MUL: alu_req = '{start: 1'b1, op: ALU_MUL};
                        OP_DIV: alu_req = '{start: (r_x != 32'd0), op: ALU_DIV};
                        OP_REM: alu_req = '{start: (r_x != 32'd0), op: ALU_REM};
                        OP_SQRT: alu_req = '{start: !r_x[31], op: ALU_SQRT};
                        OP_POW: alu_req = '{start: ($signed(r_arg) > 1), op: ALU_POW};
                        OP_PUSHM: dm_re = ri_ok && maddr_ok;
                        OP_RET: rs_re = (r_rsp != '0);
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign ds_we    = commit_ok && (fin_err == ERR_NONE) && r_push;
    assign ds_waddr = SI_W'(dsp_after);
    assign rs_we    = commit_ok && (fin_err == ERR_NONE) && r_rpush;
    assign rs_waddr = SI_W'(r_rsp);
    assign rs_wdata = RS_W'(r_pc) + RS_W'(1);
    assign dm_we    = commit_ok && (fin_err == ERR_NONE) && r_wmem;

    sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH), .AW(SI_W)) u_dstack (
        .i_clk   (i_clk),
        .i_we    (ds_we),
        .i_waddr (ds_waddr),
        .i_wdata (r_pv),
        .i_re    (ds_re),
        .i_raddr (ds_raddr),
        .o_rdata (ds_rdata)
    );

    sme_ram #(.WIDTH(RS_W), .DEPTH(STACK_DEPTH), .AW(SI_W)) u_rstack (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (rs_waddr),
        .i_wdata (rs_wdata),
        .i_re    (rs_re),
        .i_raddr (rs_raddr),
        .o_rdata (rs_rdata)
    );

    sme_dram #(.DEPTH(RAM_DEPTH), .AW(RA_W)) u_dram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (dm_we),
        .i_waddr (r_maddr),
        .i_wdata (r_x),
        .i_re    (dm_re),
        .i_raddr (reg_val[RA_W-1:0]),
        .o_rdata (dm_rdata)
    );

    sme_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_y),
        .i_b      (r_x),
        .i_exp    (r_arg),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    // register file, zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= 32'd0;
            end
        end else if (commit_ok && fin_err == ERR_NONE && r_wreg) begin
            r_regs[r_ridx] <= r_x;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_dsp     <= '0;
            r_rsp     <= '0;
            r_stopped <= 1'b0;
            r_err     <= ERR_NONE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_COMMIT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_op    <= i_action;
                        r_arg   <= i_argument;
                        r_inv   <= i_in_value;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_held     <= r_stopped;
                    r_pops     <= dec_pops;
                    r_npc      <= pc_ext + NPC_W'(1);
                    r_err_pend <= dec_err;
                    r_push     <= 1'b0;
                    r_halt     <= 1'b0;
                    r_outok    <= 1'b0;
                    r_wreg     <= 1'b0;
                    r_wmem     <= 1'b0;
                    r_rpush    <= 1'b0;
                    r_rpop     <= 1'b0;
                    if (r_stopped || dec_err != ERR_NONE) begin
                        r_state <= S_COMMIT;
                    end else if (dec_pops != 2'd0) begin
                        r_state <= S_X;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_X: begin
                    r_x     <= ds_rdata;
                    r_state <= (r_pops == 2'd2) ? S_Y : S_EXEC;
                end
                S_Y: begin
                    r_y     <= ds_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= exec_state;
                    case (r_op)
                        OP_PUSH: begin
                            r_push <= 1'b1;
                            r_pv   <= r_arg;
                            r_npc  <= r_npc + NPC_W'(1);
                        end
                        OP_IN: begin
                            r_push <= 1'b1;
                            r_pv   <= r_inv;
                        end
                        OP_ADD: begin
                            r_push <= 1'b1;
                            r_pv   <= r_y + r_x;
                        end
                        OP_SUB: begin
                            r_push <= 1'b1;
                            r_pv   <= r_y - r_x;
                        end
                        OP_MUL: begin
                            r_push <= 1'b1;
                        end
                        OP_DIV, OP_REM: begin
                            if (r_x == 32'd0) begin
                                r_err_pend <= ERR_ZERO_DIV;
                            end else begin
                                r_push <= 1'b1;
                            end
                        end
                        OP_SQRT: begin
                            if (r_x[31]) begin
                                r_err_pend <= ERR_NEG_SQRT;
                            end else begin
                                r_push <= 1'b1;
                            end
                        end
                        OP_POW: begin
                            r_push <= 1'b1;
                            r_npc  <= r_npc + NPC_W'(1);
                            r_pv   <= r_x;
                        end
                        OP_OUT: r_outok <= 1'b1;
                        OP_HLT: r_halt  <= 1'b1;
                        OP_PUSHREG, OP_POPREG, OP_PUSHM, OP_POPM: begin
                            r_npc  <= r_npc + NPC_W'(1);
                            r_ridx <= ri_idx;
                            r_maddr <= reg_val[RA_W-1:0];
                            if (!ri_ok) begin
                                r_err_pend <= ERR_BAD_INDEX;
                            end else if (r_op == OP_PUSHREG) begin
                                r_push <= 1'b1;
                                r_pv   <= reg_val;
                            end else if (r_op == OP_POPREG) begin
                                r_wreg <= 1'b1;
                            end else if (!maddr_ok) begin
                                r_err_pend <= ERR_BAD_INDEX;
                            end else if (r_op == OP_PUSHM) begin
                                r_push <= 1'b1;
                            end else begin
                                r_wmem <= 1'b1;
                            end
                        end
                        OP_JB:  r_npc <= ($signed(r_y) <  $signed(r_x)) ? sarg_ext + NPC_W'(1)
                                                                        : r_npc + NPC_W'(1);
                        OP_JBE: r_npc <= ($signed(r_y) <= $signed(r_x)) ? sarg_ext + NPC_W'(1)
                                                                        : r_npc + NPC_W'(1);
                        OP_JA:  r_npc <= ($signed(r_y) >  $signed(r_x)) ? sarg_ext + NPC_W'(1)
                                                                        : r_npc + NPC_W'(1);
                        OP_JAE: r_npc <= ($signed(r_y) >= $signed(r_x)) ? sarg_ext + NPC_W'(1)
                                                                        : r_npc + NPC_W'(1);
                        OP_JE:  r_npc <= (r_y == r_x) ? sarg_ext + NPC_W'(1)
                                                      : r_npc + NPC_W'(1);
                        OP_JNE: r_npc <= (r_y != r_x) ? sarg_ext + NPC_W'(1)
                                                      : r_npc + NPC_W'(1);
                        OP_JMP: r_npc <= sarg_ext + NPC_W'(1);
                        OP_CALL: begin
                            if (r_rsp == SP_W'(STACK_DEPTH)) begin
                                r_err_pend <= ERR_RET_STACK;
                            end else begin
                                r_rpush <= 1'b1;
                                r_npc   <= sarg_ext + NPC_W'(1);
                            end
                        end
                        OP_RET: begin
                            if (r_rsp == '0) begin
                                r_err_pend <= ERR_RET_STACK;
                            end else begin
                                r_rpop <= 1'b1;
                            end
                        end
                        default: ;  // DRAW does nothing
                    endcase
                end
                S_ALU: begin
                    if (alu_done) begin
                        r_pv    <= alu_res;
                        r_state <= S_COMMIT;
                    end
                end
                S_RD: begin
                    if (r_op == OP_RET) begin
                        r_npc <= $signed({{(NPC_W - RS_W){1'b0}}, rs_rdata}) + NPC_W'(1);
                    end else begin
                        r_pv <= dm_rdata;
                    end
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (r_held || fin_err != ERR_NONE) begin
                            // held or faulting: stacks and PC stay put, a new fault is latched
                            r_o_val  <= 32'd0;
                            r_o_ovld <= 1'b0;
                            r_o_halt <= 1'b1;
                            r_o_pc   <= 12'(r_pc);
                            r_o_err  <= r_held ? r_err : fin_err;
                            if (!r_held) begin
                                r_err     <= fin_err;
                                r_stopped <= 1'b1;
                            end
                        end else begin
                            r_dsp <= dsp_after + SP_W'(r_push);
                            if (r_rpush) begin
                                r_rsp <= r_rsp + SP_W'(1);
                            end else if (r_rpop) begin
                                r_rsp <= r_rsp - SP_W'(1);
                            end
                            // HLT keeps the PC on itself
                            if (!r_halt) begin
                                r_pc <= PC_W'(r_npc);
                            end
                            r_o_pc    <= r_halt ? 12'(r_pc) : 12'(PC_W'(r_npc));
                            r_o_val   <= r_outok ? r_x : 32'd0;
                            r_o_ovld  <= r_outok;
                            r_o_halt  <= r_halt;
                            r_o_err   <= r_err;
                            r_stopped <= r_halt;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_next_pc    = r_o_pc;
    assign o_out_value  = r_o_val;
    assign o_out_valid  = r_o_ovld;
    assign o_halted     = r_o_halt;
    assign o_error_code = r_o_err;

    // a stopped block stays stopped
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared");

    // a latched error always comes with the stop flag
    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> r_stopped)
        else $error("error latched without stop");

    // stack depths stay within the stack memories
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dsp <= SP_W'(STACK_DEPTH)) && (r_rsp <= SP_W'(STACK_DEPTH)))
        else $error("stack depth out of range");

    // a reported error is always reported as halted
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_err != ERR_NONE) |-> r_o_halt)
        else $error("error result not halted");

endmodule
